/* design/cclru_pkg.sv */
// Shared types and constants of the LRU word cache controller.
// Used by every module of the block; depends on nothing.
package cclru_pkg;

  localparam int unsigned LINES = 8;
  localparam int unsigned LW = $clog2(LINES);
  localparam int unsigned CW = LW + 1;

  localparam int unsigned S_TDATA_W = 48;
  localparam int unsigned M_TDATA_W = 56;

  typedef logic [LW-1:0] idx_t;
  typedef logic [LW-1:0] age_t;
  typedef logic [CW-1:0] cnt_t;

  localparam age_t AGE_TOP = age_t'(LINES - 1);
  localparam idx_t IDX_LAST = idx_t'(LINES - 1);

  localparam logic CFG_ASSOC = 1'b0;
  localparam logic CFG_WB_MODE = 1'b1;

  typedef enum logic [1:0] {
    KIND_WB    = 2'd0,
    KIND_FILL  = 2'd1,
    KIND_WT    = 2'd2,
    KIND_REPLY = 2'd3
  } kind_e;

  typedef struct packed {
    logic        valid;
    logic [15:0] tag;
    age_t        age;
    logic        dirty;
    logic [15:0] data;
  } line_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    line_t wdata;
    logic  re;
    idx_t  raddr;
  } mem_req_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] mem_address;
    logic [15:0] mem_data;
    logic        mem_byte;
    logic [15:0] read_data;
    logic        hit;
    logic        last;
  } result_t;

endpackage

/* design/cclru_store.sv */
// Line store: one entry per cache line holding tag, age, flags and data.
// Synchronous memory with one write and one registered read per cycle; uses cclru_pkg.
module cclru_store import cclru_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output line_t    rdata_o
);

  line_t mem [LINES];
  line_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/cclru_outreg.sv */
// Output register of the result stream, with tdata and tuser packing.
// Uses cclru_pkg.
module cclru_outreg import cclru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  result_t              res_i,
  output logic                 ready_o,
  output logic                 tvalid_o,
  input  logic                 tready_i,
  output logic [M_TDATA_W-1:0] tdata_o,
  output logic [1:0]           tuser_o,
  output logic                 tlast_o
);

  logic    vld_q, vld_d;
  result_t res_q;

  assign ready_o = !vld_q || tready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (tready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign tvalid_o = vld_q;
  assign tdata_o  = {6'b0, res_q.hit, res_q.read_data, res_q.mem_byte, res_q.mem_data,
                     res_q.mem_address};
  assign tuser_o  = res_q.kind;
  assign tlast_o  = res_q.last;

endmodule

/* design/cclru_ctrl.sv */
// Access sequencer: clearing pass, tag and age search sweep, decision,
// age update sweep over the line store, and result emission. Uses cclru_pkg.
module cclru_ctrl import cclru_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        assoc_i,
  input  logic        wb_mode_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [15:0] addr_i,
  input  logic        byte_i,
  input  logic [15:0] wdata_i,
  input  logic [15:0] fdata_i,
  output mem_req_t    mem_req_o,
  input  line_t       mem_rdata_i,
  input  logic        out_ready_i,
  output logic        out_load_o,
  output result_t     out_res_o
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_DEC  = 3'd4;
  localparam logic [2:0] ST_UPD  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0] state_q, state_d;
  cnt_t       cnt_q, cnt_d;
  logic       rd_vld_q, rd_vld_d;
  idx_t       rd_idx_q, rd_idx_d;
  idx_t       dix_q, dix_d;
  logic       hit_found_q, hit_found_d;
  logic [3:0] pend_q, pend_d;

  logic        act_q, byte_q;
  logic [15:0] addr_q, wd_q, fd_q;
  idx_t        hit_idx_q, hit_idx_d, vic_idx_q, vic_idx_d, sel_idx_q, sel_idx_d;
  line_t       hit_ent_q, hit_ent_d, vic_ent_q, vic_ent_d, new_ent_q, new_ent_d;
  age_t        old_age_q, old_age_d;
  logic        hit_q, hit_d;
  logic [15:0] wb_tag_q, wb_tag_d, wb_data_q, wb_data_d, rdat_q, rdat_d;

  logic        capture;
  logic        issue;
  logic        match;
  line_t       sel_ent, upd_ent;
  idx_t        sel_idx;
  logic        do_wb;
  logic [15:0] new_data;
  logic        new_dirty;

  assign issue   = (cnt_q < cnt_t'(LINES));
  assign match   = mem_rdata_i.valid && (mem_rdata_i.tag == addr_q);
  assign sel_ent = (assoc_i && hit_found_q) ? hit_ent_q : vic_ent_q;
  assign sel_idx = (assoc_i && hit_found_q) ? hit_idx_q : vic_idx_q;
  assign do_wb   = !hit_found_q && wb_mode_i && sel_ent.dirty;

  always_comb begin
    if (act_q) begin
      new_data  = byte_q ? {sel_ent.data[15:8], wd_q[7:0]} : wd_q;
      new_dirty = wb_mode_i ? 1'b1 : sel_ent.dirty;
    end else begin
      if (hit_found_q) begin
        new_data = sel_ent.data;
      end else begin
        new_data = byte_q ? {sel_ent.data[15:8], fd_q[7:0]} : fd_q;
      end
      new_dirty = do_wb ? 1'b0 : sel_ent.dirty;
    end
  end

  always_comb begin
    upd_ent = mem_rdata_i;
    if (rd_idx_q == sel_idx_q) begin
      upd_ent = new_ent_q;
    end else if (mem_rdata_i.age > old_age_q) begin
      upd_ent.age = mem_rdata_i.age - age_t'(1);
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    dix_d       = dix_q;
    hit_found_d = hit_found_q;
    pend_d      = pend_q;
    hit_idx_d   = hit_idx_q;
    hit_ent_d   = hit_ent_q;
    vic_idx_d   = vic_idx_q;
    vic_ent_d   = vic_ent_q;
    sel_idx_d   = sel_idx_q;
    new_ent_d   = new_ent_q;
    old_age_d   = old_age_q;
    hit_d       = hit_q;
    wb_tag_d    = wb_tag_q;
    wb_data_d   = wb_data_q;
    rdat_d      = rdat_q;
    capture     = 1'b0;
    in_ready_o  = 1'b0;
    mem_req_o   = '0;
    out_load_o  = 1'b0;
    out_res_o   = '0;

    case (state_q)
      ST_CLR: begin
        mem_req_o.we          = 1'b1;
        mem_req_o.waddr       = cnt_q[LW-1:0];
        mem_req_o.wdata.age   = cnt_q[LW-1:0];
        cnt_d                 = cnt_q + cnt_t'(1);
        if (cnt_q[LW-1:0] == IDX_LAST) begin
          cnt_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          capture     = 1'b1;
          cnt_d       = '0;
          hit_found_d = 1'b0;
          dix_d       = idx_t'(addr_i[15:1] % LINES);
          state_d     = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cnt_q[LW-1:0];
          cnt_d           = cnt_q + cnt_t'(1);
        end
        rd_vld_d = issue;
        rd_idx_d = cnt_q[LW-1:0];
        if (rd_vld_q) begin
          if (assoc_i) begin
            if (!hit_found_q && match) begin
              hit_found_d = 1'b1;
              hit_idx_d   = rd_idx_q;
              hit_ent_d   = mem_rdata_i;
            end
            if ((rd_idx_q == '0) || (mem_rdata_i.age < vic_ent_q.age)) begin
              vic_idx_d = rd_idx_q;
              vic_ent_d = mem_rdata_i;
            end
          end else if (rd_idx_q == dix_q) begin
            hit_found_d = match;
            vic_idx_d   = rd_idx_q;
            vic_ent_d   = mem_rdata_i;
          end
          if (rd_idx_q == IDX_LAST) begin
            state_d = ST_DEC;
          end
        end
      end
      ST_DEC: begin
        sel_idx_d       = sel_idx;
        old_age_d       = sel_ent.age;
        new_ent_d.valid = 1'b1;
        new_ent_d.tag   = addr_q;
        new_ent_d.age   = AGE_TOP;
        new_ent_d.dirty = new_dirty;
        new_ent_d.data  = new_data;
        hit_d           = hit_found_q;
        wb_tag_d        = sel_ent.tag;
        wb_data_d       = sel_ent.data;
        if (act_q) begin
          rdat_d = '0;
        end else begin
          rdat_d = byte_q ? {8'h00, new_data[7:0]} : new_data;
        end
        pend_d  = {1'b1, act_q && !wb_mode_i, !act_q && !hit_found_q, do_wb};
        cnt_d   = '0;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (issue) begin
          mem_req_o.re    = 1'b1;
          mem_req_o.raddr = cnt_q[LW-1:0];
          cnt_d           = cnt_q + cnt_t'(1);
        end
        rd_vld_d = issue;
        rd_idx_d = cnt_q[LW-1:0];
        if (rd_vld_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = rd_idx_q;
          mem_req_o.wdata = upd_ent;
          if (rd_idx_q == IDX_LAST) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_load_o              = out_ready_i;
        out_res_o.mem_address   = addr_q;
        out_res_o.mem_byte      = byte_q;
        if (pend_q[0]) begin
          out_res_o.kind        = KIND_WB;
          out_res_o.mem_address = wb_tag_q;
          out_res_o.mem_data    = wb_data_q;
          out_res_o.mem_byte    = 1'b0;
          if (out_ready_i) begin
            pend_d[0] = 1'b0;
          end
        end else if (pend_q[1]) begin
          out_res_o.kind = KIND_FILL;
          if (out_ready_i) begin
            pend_d[1] = 1'b0;
          end
        end else if (pend_q[2]) begin
          out_res_o.kind     = KIND_WT;
          out_res_o.mem_data = new_ent_q.data;
          if (out_ready_i) begin
            pend_d[2] = 1'b0;
          end
        end else begin
          out_res_o.kind      = KIND_REPLY;
          out_res_o.read_data = rdat_q;
          out_res_o.hit       = hit_q;
          out_res_o.last      = 1'b1;
          if (out_ready_i) begin
            pend_d  = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      cnt_q       <= '0;
      rd_vld_q    <= 1'b0;
      rd_idx_q    <= '0;
      dix_q       <= '0;
      hit_found_q <= 1'b0;
      pend_q      <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rd_vld_q    <= rd_vld_d;
      rd_idx_q    <= rd_idx_d;
      dix_q       <= dix_d;
      hit_found_q <= hit_found_d;
      pend_q      <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      act_q  <= action_i;
      addr_q <= addr_i;
      byte_q <= byte_i;
      wd_q   <= wdata_i;
      fd_q   <= fdata_i;
    end
    hit_idx_q <= hit_idx_d;
    hit_ent_q <= hit_ent_d;
    vic_idx_q <= vic_idx_d;
    vic_ent_q <= vic_ent_d;
    sel_idx_q <= sel_idx_d;
    new_ent_q <= new_ent_d;
    old_age_q <= old_age_d;
    hit_q     <= hit_d;
    wb_tag_q  <= wb_tag_d;
    wb_data_q <= wb_data_d;
    rdat_q    <= rdat_d;
  end

endmodule

/* design/cache_controller_lru_wb_wt_core.sv */
// Top level of the LRU word cache controller with write-back and write-through modes.
// Instantiates cclru_store, cclru_ctrl and cclru_outreg; uses cclru_pkg.
//
//   Channel    Direction  Handshake               Contents
//   s_axis     in         tvalid/tready           one access request
//   m_axis     out        tvalid/tready, tlast    bus transactions, then the reply
//   cfg        in         cfg_we_i                mode register writes
//
// An access makes two sweeps over the line store in either mode (search, then age
// update) through its single read port, and then emits its result items.
// After reset a clearing pass over all LINES entries initializes the store; no request is
// taken during it. A stalled output holds the sequencer in its emit phase.
module cache_controller_lru_wb_wt_core import cclru_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // address, write_data, fill_data
  input  logic [1:0]           s_axis_tuser,  // action, byte_access
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // mem_address, mem_data, mem_byte, read_data, hit
  output logic [1:0]           m_axis_tuser,  // kind
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic                 cfg_data_i
);

  logic     assoc_q, assoc_d;
  logic     wb_mode_q, wb_mode_d;
  mem_req_t mem_req;
  line_t    mem_rdata;
  logic     out_ready;
  logic     out_load;
  result_t  out_res;

  always_comb begin
    assoc_d   = assoc_q;
    wb_mode_d = wb_mode_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ASSOC:   assoc_d   = cfg_data_i;
        CFG_WB_MODE: wb_mode_d = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assoc_q   <= 1'b1;
      wb_mode_q <= 1'b1;
    end else begin
      assoc_q   <= assoc_d;
      wb_mode_q <= wb_mode_d;
    end
  end

  cclru_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  cclru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .assoc_i     (assoc_q),
    .wb_mode_i   (wb_mode_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .action_i    (s_axis_tuser[0]),
    .addr_i      (s_axis_tdata[15:0]),
    .byte_i      (s_axis_tuser[1]),
    .wdata_i     (s_axis_tdata[31:16]),
    .fdata_i     (s_axis_tdata[47:32]),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata),
    .out_ready_i (out_ready),
    .out_load_o  (out_load),
    .out_res_o   (out_res)
  );

  cclru_outreg u_outreg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (out_load),
    .res_i    (out_res),
    .ready_o  (out_ready),
    .tvalid_o (m_axis_tvalid),
    .tready_i (m_axis_tready),
    .tdata_o  (m_axis_tdata),
    .tuser_o  (m_axis_tuser),
    .tlast_o  (m_axis_tlast)
  );

`ifndef SYNTHESIS
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
    else $error("line store read and written at the same entry");

  a_busy_on_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
    else $error("request taken before the reply of the previous one");

  a_idle_after_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_res.last) |=> s_axis_tready)
    else $error("sequencer not idle after the reply");
`endif

endmodule
